### src/mlbb_pkg.sv
// Shared package for the multi-LED breathe/blink controller.
// Holds request codes, mode and status codes, field widths and the
// command/status structs between controller and datapath. No dependencies.
`default_nettype none

package mlbb_pkg;

  localparam int unsigned NUM_LEDS_DEF   = 8;
  localparam int unsigned PWM_PERIOD_DEF = 20;

  localparam int unsigned FUNC_W   = 3;
  localparam int unsigned INDEX_W  = 4;
  localparam int unsigned LEVEL_W  = 8;
  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned COUNT_W  = 8;
  localparam int unsigned PINS_W   = 8;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned CNT_W    = 14;
  localparam int unsigned MODE_W   = 2;

  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 16;

  localparam logic [FUNC_W-1:0] FUNC_TICK   = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_ON     = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_OFF    = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_TOGGLE = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_LEVEL  = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_GRAD   = 3'd5;
  localparam logic [FUNC_W-1:0] FUNC_FLASH  = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_QUERY  = 3'd7;

  localparam logic [MODE_W-1:0] MODE_PLAIN   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BREATHE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FLASH   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OFF         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_ON          = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BREATHE_OFF = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BREATHE_ON  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FLASH_OFF   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FLASH_ON    = 3'd5;

  localparam logic [PERIOD_W-1:0] FLASH_MIN  = 16'd2;
  localparam logic [PERIOD_W-1:0] FLASH_MAX  = 16'd30000;
  localparam logic [LEVEL_W-1:0]  LEVEL_FULL = 8'hFF;

  typedef struct packed {
    logic capture;
    logic step;
    logic load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic last;
    logic out_busy;
  } dp_stat_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              lit;
    logic [CNT_W-1:0]  phase;
    logic [CNT_W-1:0]  duty;
    logic [CNT_W-1:0]  goal;
  } led_entry_t;

endpackage

`default_nettype wire

### src/multi_led_breathe_blink_controller.sv
// Multi-LED breathe/blink controller, top level.
// Request stream in (s_axis), result stream out (m_axis), one polarity
// register. Depends on mlbb_pkg, mlbb_ctrl and mlbb_datapath.
//
// Each request carries a function code in tuser and the LED index, level,
// flash period and flash count in tdata. Every request yields exactly one
// result: the pin levels of LEDs 0..7 and the status of the addressed LED.
// A tick walks the channel update unit over all LEDs, one per cycle; any
// other request updates one channel. After the last channel update the
// sequencer waits in its done state until the output register is free,
// then loads the result into the output register.
// The output register decouples the two sides: a new request is accepted
// while a result waits; its own result is held back until the previous one
// has been taken, so a stalled receiver stalls the request side too.
// Reset puts all LEDs in plain mode, dark, and sets active_high to 1.
// cfg_we_i/cfg_wdata_i write active_high; write only while idle.
`default_nettype none

module multi_led_breathe_blink_controller #(
  parameter int unsigned NUM_LEDS   = mlbb_pkg::NUM_LEDS_DEF,
  parameter int unsigned PWM_PERIOD = mlbb_pkg::PWM_PERIOD_DEF
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                cfg_we_i,
  input  wire                                cfg_wdata_i,
  input  wire                                s_axis_tvalid,
  output logic                               s_axis_tready,
  // [3:0] led_index, [11:4] level, [27:12] period_ms, [35:28] flash_count
  input  wire [mlbb_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // [2:0] func
  input  wire [mlbb_pkg::FUNC_W-1:0]         s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  wire                                m_axis_tready,
  // [7:0] pin_levels, [10:8] status
  output logic [mlbb_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
  import mlbb_pkg::*;

  ctrl_cmd_t           cmd;
  dp_stat_t            stat;
  logic [PINS_W-1:0]   pins;
  logic [STATUS_W-1:0] status;

  mlbb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  mlbb_datapath #(
    .NUM_LEDS   (NUM_LEDS),
    .PWM_PERIOD (PWM_PERIOD)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .func_i        (s_axis_tuser),
    .led_index_i   (s_axis_tdata[3:0]),
    .level_i       (s_axis_tdata[11:4]),
    .period_ms_i   (s_axis_tdata[27:12]),
    .flash_count_i (s_axis_tdata[35:28]),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .out_ready_i   (m_axis_tready),
    .out_valid_o   (m_axis_tvalid),
    .pin_levels_o  (pins),
    .status_o      (status)
  );

  assign m_axis_tdata = {{(OUT_DATA_W - PINS_W - STATUS_W){1'b0}}, status, pins};

  a_one_request_at_a_time: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready
  ) else $error("request accepted while previous one in progress");

  a_status_legal: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[10:8] <= ST_FLASH_ON)
  ) else $error("status code out of range");

  a_absent_pins_zero: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((m_axis_tdata[7:0] >> NUM_LEDS) == '0)
  ) else $error("pin level set for absent LED");

  a_load_only_when_free: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (cmd.load && m_axis_tvalid) |-> m_axis_tready
  ) else $error("result overwritten before it was taken");

endmodule

`default_nettype wire

### src/mlbb_ctrl.sv
// Sequencer for the multi-LED controller: accepts a request, walks the
// datapath over one or all LED channels, then loads the output register.
// Depends on mlbb_pkg.
`default_nettype none

module mlbb_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  req_valid_i,
  output logic                 req_ready_o,
  input  mlbb_pkg::dp_stat_t   stat_i,
  output mlbb_pkg::ctrl_cmd_t  cmd_o
);
  import mlbb_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WORK = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    req_ready_o   = 1'b0;
    case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_WORK;
        end
      end
      S_WORK: begin
        cmd_o.step = 1'b1;
        if (stat_i.last) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!stat_i.out_busy) begin
          cmd_o.load = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

### src/mlbb_datapath.sv
// Datapath for the multi-LED controller: request registers, per-LED state,
// one shared channel update unit, polarity register and output register.
// Depends on mlbb_pkg; driven by mlbb_ctrl.
`default_nettype none

module mlbb_datapath #(
  parameter int unsigned NUM_LEDS   = mlbb_pkg::NUM_LEDS_DEF,
  parameter int unsigned PWM_PERIOD = mlbb_pkg::PWM_PERIOD_DEF
) (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  mlbb_pkg::ctrl_cmd_t                   cmd_i,
  output mlbb_pkg::dp_stat_t                    stat_o,
  input  wire [mlbb_pkg::FUNC_W-1:0]            func_i,
  input  wire [mlbb_pkg::INDEX_W-1:0]           led_index_i,
  input  wire [mlbb_pkg::LEVEL_W-1:0]           level_i,
  input  wire [mlbb_pkg::PERIOD_W-1:0]          period_ms_i,
  input  wire [mlbb_pkg::COUNT_W-1:0]           flash_count_i,
  input  wire                                   cfg_we_i,
  input  wire                                   cfg_wdata_i,
  input  wire                                   out_ready_i,
  output logic                                  out_valid_o,
  output logic [mlbb_pkg::PINS_W-1:0]           pin_levels_o,
  output logic [mlbb_pkg::STATUS_W-1:0]         status_o
);
  import mlbb_pkg::*;

  localparam int unsigned LED_W  = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
  localparam int unsigned PROD_W = 17;
  localparam logic [CNT_W-1:0] PERIOD_C = CNT_W'(PWM_PERIOD);

  logic [FUNC_W-1:0]   func_q;
  logic [INDEX_W-1:0]  idx_q;
  logic [LEVEL_W-1:0]  level_q;
  logic [PERIOD_W-1:0] period_q;
  logic [COUNT_W-1:0]  count_q;
  logic [LED_W-1:0]    ptr_q;
  logic                active_high_q;
  logic                out_valid_q;
  logic [PINS_W-1:0]   pins_q;
  logic [STATUS_W-1:0] status_q;
  led_entry_t          entry_q [NUM_LEDS];

  logic                idx_ok;
  logic [LED_W-1:0]    idx_led;
  logic                is_tick;
  led_entry_t          cur;
  led_entry_t          nxt;
  logic [STATUS_W-1:0] cur_st;
  logic [LEVEL_W-1:0]  lvl_eff;
  logic [PROD_W-1:0]   prod;
  logic [PROD_W-1:0]   goal_full;
  logic [PERIOD_W-1:0] per_clamp;
  logic [CNT_W-1:0]    ph_inc;
  logic [CNT_W-1:0]    ph;
  logic [CNT_W-1:0]    dt;
  logic                lt;
  logic [PINS_W-1:0]   pins_now;

  function automatic logic [STATUS_W-1:0] status_of(led_entry_t e);
    logic [STATUS_W-1:0] s;
    case (e.mode)
      MODE_BREATHE: s = (e.goal < PERIOD_C) ? ST_BREATHE_ON : ST_BREATHE_OFF;
      MODE_FLASH:   s = e.lit ? ST_FLASH_ON : ST_FLASH_OFF;
      default:      s = e.lit ? ST_ON : ST_OFF;
    endcase
    return s;
  endfunction

  assign idx_ok  = ({1'b0, idx_q} < (INDEX_W + 1)'(NUM_LEDS));
  assign idx_led = LED_W'(idx_q);
  assign is_tick = (func_q == FUNC_TICK);

  assign stat_o.last     = !is_tick || (ptr_q == LED_W'(NUM_LEDS - 1));
  assign stat_o.out_busy = out_valid_q && !out_ready_i;

  // channel update unit
  always_comb begin
    cur       = entry_q[ptr_q];
    nxt       = cur;
    cur_st    = status_of(cur);
    lvl_eff   = (func_q == FUNC_GRAD) ? (cur_st[0] ? LEVEL_FULL : '0) : level_q;
    prod      = PROD_W'(lvl_eff) * PROD_W'(PWM_PERIOD);
    // floor(prod / 255), exact for prod below 65535
    goal_full = (prod + (prod >> 8) + PROD_W'(1)) >> 8;
    per_clamp = (period_q < FLASH_MIN) ? FLASH_MIN :
                (period_q > FLASH_MAX) ? FLASH_MAX : period_q;
    ph_inc    = cur.phase + CNT_W'(1);
    ph        = ph_inc;
    dt        = cur.duty;
    lt        = cur.lit;
    case (func_q)
      FUNC_TICK: begin
        if (cur.mode == MODE_BREATHE) begin
          if (ph_inc >= PERIOD_C) begin
            lt = 1'b0;
            ph = '0;
            if (cur.duty < cur.goal) begin
              dt = cur.duty + CNT_W'(1);
            end else if (cur.duty > cur.goal) begin
              dt = cur.duty - CNT_W'(1);
            end
          end
          if (ph == dt) begin
            lt = 1'b1;
          end
          nxt.phase = ph;
          nxt.duty  = dt;
          nxt.lit   = lt;
        end else if (cur.mode == MODE_FLASH) begin
          nxt.phase = ph_inc;
          if (ph_inc >= cur.duty) begin
            nxt.phase = '0;
            nxt.lit   = !cur.lit;
            if (cur.goal != '0) begin
              nxt.goal = cur.goal - CNT_W'(1);
              if (cur.goal == CNT_W'(1)) begin
                nxt = '0;
              end
            end
          end
        end
      end
      FUNC_ON: begin
        nxt     = '0;
        nxt.lit = 1'b1;
      end
      FUNC_OFF: begin
        nxt = '0;
      end
      FUNC_TOGGLE: begin
        nxt     = '0;
        nxt.lit = !cur.lit;
      end
      FUNC_LEVEL, FUNC_GRAD: begin
        if (cur_st == ST_ON || cur_st == ST_FLASH_ON) begin
          nxt.duty = '0;
        end else if (cur_st == ST_OFF || cur_st == ST_FLASH_OFF) begin
          nxt.duty = PERIOD_C;
        end
        nxt.phase = '0;
        nxt.goal  = CNT_W'(goal_full);
        nxt.mode  = MODE_BREATHE;
      end
      FUNC_FLASH: begin
        nxt.phase = '0;
        nxt.duty  = CNT_W'(per_clamp >> 1);
        nxt.goal  = CNT_W'({count_q, 1'b0});
        nxt.lit   = 1'b1;
        nxt.mode  = MODE_FLASH;
      end
      FUNC_QUERY: begin
        nxt = cur;
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

  for (genvar g = 0; g < PINS_W; g++) begin : g_pin
    if (g < NUM_LEDS) begin : g_used
      assign pins_now[g] = entry_q[g].lit ^ !active_high_q;
    end else begin : g_absent
      assign pins_now[g] = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q   <= func_i;
      idx_q    <= led_index_i;
      level_q  <= level_i;
      period_q <= period_ms_i;
      count_q  <= flash_count_i;
    end
    if (cmd_i.load) begin
      pins_q   <= pins_now;
      status_q <= idx_ok ? cur_st : ST_OFF;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q         <= '0;
      active_high_q <= 1'b1;
      out_valid_q   <= 1'b0;
      for (int i = 0; i < NUM_LEDS; i++) begin
        entry_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        active_high_q <= cfg_wdata_i;
      end
      if (cmd_i.capture) begin
        ptr_q <= (func_i == FUNC_TICK) ? '0 : LED_W'(led_index_i);
      end else if (cmd_i.step) begin
        if (is_tick || idx_ok) begin
          entry_q[ptr_q] <= nxt;
        end
        // park on the addressed LED for the status read
        ptr_q <= stat_o.last ? idx_led : ptr_q + LED_W'(1);
      end
      if (cmd_i.load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pin_levels_o = pins_q;
  assign status_o     = status_q;

endmodule

`default_nettype wire
